### hw/rtl/svmg_pkg.sv
package svmg_pkg;

   localparam int SampleWidth = 24;
   localparam int VolumeWidth = 16;
   localparam int GainWidth   = 9;
   // Signed sample times a gain of at most 256 fits in 33 bits.
   localparam int ProductWidth = SampleWidth + GainWidth;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] REG_MASTER_MUTE  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_LEFT_MUTE    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_RIGHT_MUTE   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_LEFT_VOLUME  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_RIGHT_VOLUME = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_SAMPLE_WIDTH = 3'd5;

   localparam logic [GainWidth-1:0] UNITY_GAIN = 9'd256;
   // Any volume at or below one unity step below zero floors the gain at zero,
   // which also covers the most negative value of the volume register.
   localparam logic signed [VolumeWidth-1:0] VOL_FLOOR = -16'sd256;

   localparam logic signed [SampleWidth:0] MAX24 = 25'sh07FFFFF;
   localparam logic signed [SampleWidth:0] MIN24 = -25'sh0800000;
   localparam logic signed [SampleWidth:0] MAX16 = 25'sd32767;
   localparam logic signed [SampleWidth:0] MIN16 = -25'sd32768;

   typedef logic signed [SampleWidth-1:0]  sample_type;
   typedef logic signed [VolumeWidth-1:0]  volume_type;
   typedef logic signed [ProductWidth-1:0] product_type;

   // Control that travels beside the lane products in the first stage.
   typedef struct packed {
      logic valid;
      logic last;
      logic wide;
   } stage_ctrl_type;

endpackage

### hw/rtl/svmg_if.sv
interface svmg_req_if import svmg_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type left_in;
   sample_type right_in;
   logic       in_last;

   modport source (output valid, left_in, right_in, in_last, input ready);
   modport sink (input valid, left_in, right_in, in_last, output ready);
endinterface

interface svmg_rsp_if import svmg_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type left_out;
   sample_type right_out;
   logic       out_last;

   modport source (output valid, left_out, right_out, out_last, input ready);
   modport sink (input valid, left_out, right_out, out_last, output ready);
endinterface

interface svmg_csr_if import svmg_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [CsrDataWidth-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/svmg_lane.sv
module svmg_lane import svmg_pkg::*; (
   input  logic        clock,
   input  logic        enable,
   input  sample_type  sample,
   input  logic        wide,
   input  volume_type  volume,
   input  logic        muted,
   output product_type product_ff
);

   logic [GainWidth-1:0] gain;
   sample_type           sample_ext;
   product_type          product_in;

   // A muted channel simply gets a gain of zero.
   always_comb begin
      if (muted || (volume <= VOL_FLOOR)) begin
         gain = '0;
      end else if (volume > 0) begin
         gain = UNITY_GAIN;
      end else begin
         gain = UNITY_GAIN + GainWidth'(volume);
      end
   end

   assign sample_ext = wide ? sample : {{(SampleWidth-16){sample[15]}}, sample[15:0]};
   // Both operands are widened to the product width first, so the signed product is
   // formed at full width.
   assign product_in = product_type'(sample_ext) * product_type'($signed({1'b0, gain}));

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

endmodule

### hw/rtl/svmg_merge.sv
module svmg_merge import svmg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  stage_ctrl_type ctrl,
   input  product_type    left_product,
   input  product_type    right_product,
   svmg_rsp_if.source     rsp
);

   logic       valid_ff, valid_in;
   logic       last_ff;
   logic       wide_ff;
   sample_type left_ff, left_in;
   sample_type right_ff, right_in;

   // Divide by 256 rounding toward zero, then clip to the sample width.
   function automatic sample_type scale_sat(product_type p, logic wide);
      logic signed [SampleWidth:0] q;
      logic signed [SampleWidth:0] hi;
      logic signed [SampleWidth:0] lo;
      product_type                 biased;
      biased = p + (p[ProductWidth-1] ? product_type'(255) : product_type'(0));
      q  = (SampleWidth+1)'(biased >>> 8);
      hi = wide ? MAX24 : MAX16;
      lo = wide ? MIN24 : MIN16;
      if (q > hi) begin
         q = hi;
      end else if (q < lo) begin
         q = lo;
      end
      return q[SampleWidth-1:0];
   endfunction

   assign left_in  = scale_sat(left_product, ctrl.wide);
   assign right_in = scale_sat(right_product, ctrl.wide);
   assign valid_in = ctrl.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         last_ff  <= ctrl.last;
         wide_ff  <= ctrl.wide;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.left_out  = left_ff;
   assign rsp.right_out = right_ff;
   assign rsp.out_last  = last_ff;

   a_new_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(ctrl.valid))
      else $error("result appeared without a frame in the first stage");

   a_stage_moves_forward: assert property (@(posedge clock) disable iff (reset)
      (enable && ctrl.valid) |=> valid_ff)
      else $error("frame in first stage was lost");

   a_narrow_in_range: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !wide_ff) |->
         ((left_ff[23:15] == 9'h000 || left_ff[23:15] == 9'h1FF) &&
          (right_ff[23:15] == 9'h000 || right_ff[23:15] == 9'h1FF)))
      else $error("16-bit result not saturated");

endmodule

### hw/rtl/stereo_volume_mute_gain_top.sv
// Channel  Direction  Handshake      Payload
// req      in         valid/ready    left_in[24], right_in[24], in_last
// rsp      out        valid/ready    left_out[24], right_out[24], out_last
// csr      in         valid/ready    index[3], data[16] (ready always high)
//
// One frame per cycle is accepted while the output is not stalled; each frame
// passes through the registered lane multipliers and then the output register.
// Reset is synchronous and active high; it clears the configuration registers
// to zero and empties the pipeline.
// When a result is held by a stalled sink, the whole two-stage pipeline
// freezes and req.ready drops until the result transaction completes.
module stereo_volume_mute_gain_top import svmg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   svmg_req_if.sink   req,
   svmg_rsp_if.source rsp,
   svmg_csr_if.sink   csr
);

   // Configuration registers.
   logic       master_mute_ff;
   logic       left_mute_ff;
   logic       right_mute_ff;
   volume_type left_volume_ff;
   volume_type right_volume_ff;
   logic       sample_width_ff;

   // The pipeline advances whenever the output register is empty or its
   // result transaction completes in this cycle.
   logic           advance;
   stage_ctrl_type ctrl_ff, ctrl_in;
   product_type    left_product;
   product_type    right_product;

   assign csr.ready = 1'b1;

   // Writes to indexes beyond the register list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         master_mute_ff  <= 1'b0;
         left_mute_ff    <= 1'b0;
         right_mute_ff   <= 1'b0;
         left_volume_ff  <= '0;
         right_volume_ff <= '0;
         sample_width_ff <= 1'b0;
      end else if (csr.valid) begin
         case (csr.index)
            REG_MASTER_MUTE:  master_mute_ff  <= csr.data[0];
            REG_LEFT_MUTE:    left_mute_ff    <= csr.data[0];
            REG_RIGHT_MUTE:   right_mute_ff   <= csr.data[0];
            REG_LEFT_VOLUME:  left_volume_ff  <= volume_type'(csr.data);
            REG_RIGHT_VOLUME: right_volume_ff <= volume_type'(csr.data);
            REG_SAMPLE_WIDTH: sample_width_ff <= csr.data[0];
            default: begin
            end
         endcase
      end
   end

   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   assign ctrl_in.valid = req.valid;
   assign ctrl_in.last  = req.in_last;
   assign ctrl_in.wide  = sample_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   // Both channels run through identical lanes; the merge stage finishes the
   // scaling and presents the combined frame.
   svmg_lane u_lane_left (
      .clock      (clock),
      .enable     (advance),
      .sample     (req.left_in),
      .wide       (sample_width_ff),
      .volume     (left_volume_ff),
      .muted      (master_mute_ff || left_mute_ff),
      .product_ff (left_product)
   );

   svmg_lane u_lane_right (
      .clock      (clock),
      .enable     (advance),
      .sample     (req.right_in),
      .wide       (sample_width_ff),
      .volume     (right_volume_ff),
      .muted      (master_mute_ff || right_mute_ff),
      .product_ff (right_product)
   );

   svmg_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .enable        (advance),
      .ctrl          (ctrl_ff),
      .left_product  (left_product),
      .right_product (right_product),
      .rsp           (rsp)
   );

endmodule
